### src/assert_macros.svh
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define CHK_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

### src/gbm_pkg.sv
// Package: types, constants and codes for the gap buffer block.
`default_nettype none
package gbm_pkg;
    localparam int CAPACITY     = 4096;
    localparam int MARKER_SLOTS = 8;
    localparam int AW           = $clog2(CAPACITY);
    localparam int PW           = 13;
    localparam int MW           = (MARKER_SLOTS > 1) ? $clog2(MARKER_SLOTS) : 1;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0, OP_DELETE = 3'd1, OP_GOTO = 3'd2, OP_READ = 3'd3,
        OP_SET_MARK = 3'd4, OP_READ_MARK = 3'd5, OP_DETACH = 3'd6, OP_NOP = 3'd7
    } opcode_t;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SHIFT, S_EDIT, S_MARK, S_READ, S_DONE
    } state_t;

    typedef struct packed {
        logic load;      // capture input item
        logic decide;    // compute clipped values
        logic shift;     // move one byte of the gap
        logic edit;      // apply edit to gap/cursor
        logic mark;      // update one marker
        logic rd;        // issue memory read
        logic finish;    // form result
    } cmd_t;

    typedef struct packed {
        logic need_shift;
        logic shift_done;
        logic mark_last;
        logic is_read;
    } stat_t;
endpackage
`default_nettype wire

### src/gbm_ctrl.sv
// Controller state machine sequencing the datapath per command.
`default_nettype none
module gbm_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_fire,
    input  wire logic          out_free,
    input  gbm_pkg::stat_t     st,
    output logic               busy,
    output gbm_pkg::cmd_t      cmd
);
    import gbm_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (st.need_shift && !st.shift_done)
                begin
                    cmd.shift = 1'b1;
                end
                else if (st.is_read)
                begin
                    cmd.rd = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.mark = 1'b1;
                if (st.mark_last)
                begin
                    state_next = S_EDIT;
                end
            end
            S_EDIT:
            begin
                cmd.edit = 1'b1;
                state_next = S_DONE;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### src/gbm_datapath.sv
// Datapath: text memory, gap pointers, cursor, marker table, result.
`default_nettype none
module gbm_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  gbm_pkg::cmd_t         cmd,
    input  wire logic [2:0]       opcode,
    input  wire logic [7:0]       byte_value,
    input  wire logic [12:0]      count,
    input  wire logic [12:0]      position,
    input  wire logic [2:0]       marker_index,
    input  wire logic             advance_on_insert,
    output gbm_pkg::stat_t        st,
    output logic [1:0]            status,
    output logic [7:0]            read_byte,
    output logic [12:0]           reported_position,
    output logic [12:0]           text_length,
    output logic                  modified
);
    import gbm_pkg::*;

    logic [7:0] mem [CAPACITY];
    logic [7:0] rdata_reg;
    logic [AW:0] gs_reg, ge_reg, cur_reg;
    logic        mod_reg;
    logic [AW:0] mpos_reg [MARKER_SLOTS];
    logic [MARKER_SLOTS-1:0] madv_reg, matt_reg;

    logic [2:0]  op_reg;
    logic [7:0]  bv_reg;
    logic [12:0] cnt_reg, pos_reg;
    logic [2:0]  mi_reg;
    logic        adv_reg;
    logic [AW:0] ccnt_reg, cpos_reg;
    logic        full_reg, nil_reg, badidx_reg;
    logic [MW-1:0] mptr_reg;
    // gap move: phase 0 reads the source byte, phase 1 writes it and steps the gap
    logic        sh_phase_reg;
    logic [7:0]  sh_data_reg;

    logic [AW:0] len;
    logic        edits;
    assign len = (AW+1)'(CAPACITY) - (ge_reg - gs_reg);
    assign edits = (op_reg == OP_INSERT && !full_reg)
                   || (op_reg == OP_DELETE && !nil_reg);

    assign st.need_shift = edits;
    assign st.shift_done = (gs_reg == cur_reg);
    assign st.mark_last  = (mptr_reg == MW'(MARKER_SLOTS - 1));
    assign st.is_read    = (op_reg == OP_READ);

    // clipped values from the wide input
    logic [13:0] pos_clip, rem;
    always_comb
    begin
        pos_clip = ({1'b0, pos_reg} > 14'(len)) ? 14'(len) : {1'b0, pos_reg};
        rem = 14'(len - cur_reg);
        if ({1'b0, cnt_reg} < rem)
        begin
            rem = {1'b0, cnt_reg};
        end
    end

    logic [AW:0] src_addr;
    assign src_addr = (cur_reg < gs_reg) ? gs_reg - 1'b1 : ge_reg;
    logic [AW:0] phys;
    assign phys = (cpos_reg < gs_reg) ? cpos_reg : cpos_reg + (ge_reg - gs_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode; bv_reg <= byte_value; cnt_reg <= count;
            pos_reg <= position; mi_reg <= marker_index; adv_reg <= advance_on_insert;
        end
        if (cmd.decide)
        begin
            ccnt_reg <= (AW+1)'(rem);
            cpos_reg <= (AW+1)'(pos_clip);
            full_reg <= (len == (AW+1)'(CAPACITY));
            nil_reg  <= (cnt_reg == 13'd0);
            badidx_reg <= ({29'd0, mi_reg} >= MARKER_SLOTS);
        end
        if (cmd.shift)
        begin
            if (!sh_phase_reg)
            begin
                sh_data_reg <= mem[AW'(src_addr)];
            end
            else if (cur_reg < gs_reg)
            begin
                mem[AW'(ge_reg - 1'b1)] <= sh_data_reg;
            end
            else
            begin
                mem[AW'(gs_reg)] <= sh_data_reg;
            end
        end
        if (cmd.edit && op_reg == OP_INSERT && !full_reg)
        begin
            mem[AW'(gs_reg)] <= bv_reg;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[AW'(phys)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gs_reg <= '0; ge_reg <= (AW+1)'(CAPACITY); cur_reg <= '0; mod_reg <= 1'b0;
            madv_reg <= '0; matt_reg <= '0; mptr_reg <= '0;
            sh_phase_reg <= 1'b0;
            for (int i = 0; i < MARKER_SLOTS; i++)
            begin
                mpos_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.shift)
            begin
                sh_phase_reg <= !sh_phase_reg;
                if (sh_phase_reg)
                begin
                    if (cur_reg < gs_reg)
                    begin
                        gs_reg <= gs_reg - 1'b1; ge_reg <= ge_reg - 1'b1;
                    end
                    else
                    begin
                        gs_reg <= gs_reg + 1'b1; ge_reg <= ge_reg + 1'b1;
                    end
                end
            end
            if (cmd.mark)
            begin
                mptr_reg <= st.mark_last ? '0 : mptr_reg + 1'b1;
                if (matt_reg[mptr_reg] && edits)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        if (mpos_reg[mptr_reg] > cur_reg
                            || (mpos_reg[mptr_reg] == cur_reg && madv_reg[mptr_reg]))
                        begin
                            mpos_reg[mptr_reg] <= mpos_reg[mptr_reg] + 1'b1;
                        end
                    end
                    else if (mpos_reg[mptr_reg] >= cur_reg + ccnt_reg)
                    begin
                        mpos_reg[mptr_reg] <= mpos_reg[mptr_reg] - ccnt_reg;
                    end
                    else if (mpos_reg[mptr_reg] > cur_reg)
                    begin
                        mpos_reg[mptr_reg] <= cur_reg;
                    end
                end
            end
            if (cmd.edit)
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!full_reg)
                        begin
                            gs_reg <= gs_reg + 1'b1; cur_reg <= cur_reg + 1'b1;
                            mod_reg <= 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!nil_reg)
                        begin
                            ge_reg <= ge_reg + ccnt_reg; mod_reg <= 1'b1;
                        end
                    end
                    OP_GOTO: cur_reg <= cpos_reg;
                    OP_SET_MARK:
                    begin
                        if (!badidx_reg)
                        begin
                            matt_reg[MW'(mi_reg)] <= 1'b1;
                            madv_reg[MW'(mi_reg)] <= adv_reg;
                            mpos_reg[MW'(mi_reg)] <= cpos_reg;
                        end
                    end
                    OP_DETACH:
                    begin
                        if (!badidx_reg)
                        begin
                            matt_reg[MW'(mi_reg)] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result from current state
    always_comb
    begin
        status = ST_OK;
        read_byte = 8'd0;
        reported_position = 13'(cur_reg);
        case (op_reg)
            OP_INSERT: if (full_reg) status = ST_FULL;
            OP_READ:
            begin
                if (cpos_reg >= len || {1'b0, pos_reg} > 14'(len)) status = ST_BAD;
                else read_byte = rdata_reg;
            end
            OP_SET_MARK, OP_DETACH: if (badidx_reg) status = ST_BAD;
            OP_READ_MARK:
            begin
                if (badidx_reg || !matt_reg[MW'(mi_reg)])
                begin
                    status = ST_BAD; reported_position = 13'd0;
                end
                else reported_position = 13'(mpos_reg[MW'(mi_reg)]);
            end
            default: ;
        endcase
    end
    assign text_length = 13'(len);
    assign modified = mod_reg;
endmodule
`default_nettype wire

### src/gap_buffer_with_markers_unit.sv
// Top level of the gap buffer text store with cursor and markers.
// Usage:
//  - s_axis carries one command per transfer; m_axis returns one result.
//  - s_axis_tdata fields low to high: opcode, byte_value, count, position,
//    marker_index, advance_on_insert (41 bits, padded to 48).
//  - m_axis_tdata fields low to high: status, read_byte, reported_position,
//    text_length, modified (37 bits, padded to 40).
//  - One command at a time. Steps: decide, then gap moves to reach the
//    cursor (insert/delete only), then one marker slot after another
//    (8 slots) and the edit for every command that does not read a byte.
//    Gap moves copy each byte with a registered read, then a write.
//  - The result sits in an output register; s_axis_tready rises again as
//    soon as it is loaded, so the next command proceeds while the result
//    waits, and stalls only when a second result would be due.
//  - Reset: empty text, cursor 0, all markers detached, modified clear.
//    Text memory is not cleared; only written bytes are ever returned.
`default_nettype none
module gap_buffer_with_markers_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // opcode,byte_value,count,position,marker_index,advance
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // status,read_byte,reported_position,text_length,modified
);
    import gbm_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  busy, in_fire, out_free;
    logic [1:0]  status;
    logic [7:0]  rbyte;
    logic [12:0] rpos, tlen;
    logic        modf;
    logic [39:0] out_reg;
    logic        ov_reg;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !ov_reg || m_axis_tready;

    gbm_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .st(st), .busy(busy), .cmd(cmd)
    );

    gbm_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .opcode(s_axis_tdata[2:0]), .byte_value(s_axis_tdata[10:3]),
        .count(s_axis_tdata[23:11]), .position(s_axis_tdata[36:24]),
        .marker_index(s_axis_tdata[39:37]), .advance_on_insert(s_axis_tdata[40]),
        .st(st), .status(status), .read_byte(rbyte), .reported_position(rpos),
        .text_length(tlen), .modified(modf)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            ov_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_reg <= {3'd0, modf, tlen, rpos, rbyte, status};
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = out_reg;
endmodule
`default_nettype wire

### src/gbm_checker.sv
// Port-level checker for the gap buffer unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module gbm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    `CHK_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CHK_IMPLY(a_status_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
    `CHK_IMPLY(a_len_cap, clk, rst_n, m_axis_tvalid, m_axis_tdata[35:23] <= 13'd4096)
    `CHK_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
bind gap_buffer_with_markers_unit gbm_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

### test/gap_buffer_with_markers_unit_checker.sv
// Checker: predicts gap buffer results from observed commands and compares them.
module gap_buffer_with_markers_unit_checker
    import gbm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    output int               fail_count,
    output int               pending_count,
    output int               result_count
);
    // declared high to low so that status sits in the lowest bits
    typedef struct packed {
        logic          modified;
        logic [PW-1:0] text_len;
        logic [PW-1:0] rep_pos;
        logic [7:0]    rd_byte;
        logic [1:0]    status;
    } result_t;

    // Logical text kept flat; the gap is an RTL detail.
    logic [7:0]    text_q[$];
    int            cur;
    logic          mod_flag;
    int            mark_pos[MARKER_SLOTS];
    logic          mark_adv[MARKER_SLOTS];
    logic          mark_att[MARKER_SLOTS];
    result_t       expected_q[$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 result_count);
        fail_count++;
    endtask

    function automatic result_t apply_command(input logic [47:0] d);
        opcode_t    op;
        logic [7:0] bv;
        int         cnt, pos, mi, len;
        result_t    r;
        op  = opcode_t'(d[2:0]);
        bv  = d[10:3];
        cnt = int'(d[23:11]);
        pos = int'(d[36:24]);
        mi  = int'(d[39:37]);
        len = text_q.size();
        r = '0;
        r.rep_pos = '0;
        case (op)
            OP_INSERT:
            begin
                if (len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    text_q.insert(cur, bv);
                    for (int i = 0; i < MARKER_SLOTS; i++)
                        if (mark_att[i] && (mark_pos[i] > cur || (mark_pos[i] == cur && mark_adv[i])))
                            mark_pos[i]++;
                    cur++;
                    mod_flag = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (cnt != 0)
                begin
                    if (cnt > len - cur)
                        cnt = len - cur;
                    for (int k = 0; k < cnt; k++)
                        text_q.delete(cur);
                    for (int i = 0; i < MARKER_SLOTS; i++)
                        if (mark_att[i])
                        begin
                            if (mark_pos[i] >= cur + cnt)
                                mark_pos[i] -= cnt;
                            else if (mark_pos[i] > cur)
                                mark_pos[i] = cur;
                        end
                    mod_flag = 1'b1;
                end
            end
            OP_GOTO:
                cur = (pos > len) ? len : pos;
            OP_READ:
            begin
                if (pos >= len)
                    r.status = ST_BAD;
                else
                    r.rd_byte = text_q[pos];
            end
            OP_SET_MARK:
            begin
                mark_att[mi] = 1'b1;
                mark_adv[mi] = d[40];
                mark_pos[mi] = (pos > len) ? len : pos;
            end
            OP_DETACH:
                mark_att[mi] = 1'b0;
            default: ;
        endcase
        if (op == OP_READ_MARK)
        begin
            if (!mark_att[mi])
                r.status = ST_BAD;
            else
                r.rep_pos = PW'(mark_pos[mi]);
        end
        else
            r.rep_pos = PW'(cur);
        r.text_len = PW'(text_q.size());
        r.modified = mod_flag;
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        result_count = 0;
        pending_count = 0;
        cur = 0;
        mod_flag = 1'b0;
        for (int i = 0; i < MARKER_SLOTS; i++)
        begin
            mark_pos[i] = 0;
            mark_adv[i] = 1'b0;
            mark_att[i] = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_q.push_back(apply_command(s_axis_tdata));
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[36:0];
            if (expected_q.size() == 0)
            begin
                $display("unexpected result transfer %0d", result_count);
                fail_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.rd_byte != want.rd_byte)
                    report_mismatch("read_byte", got.rd_byte, want.rd_byte);
                if (got.rep_pos != want.rep_pos)
                    report_mismatch("reported_position", got.rep_pos, want.rep_pos);
                if (got.text_len != want.text_len)
                    report_mismatch("text_length", got.text_len, want.text_len);
                if (got.modified != want.modified)
                    report_mismatch("modified", got.modified, want.modified);
            end
            result_count++;
        end
        pending_count = expected_q.size();
    end
endmodule

### test/gap_buffer_with_markers_unit_tb.sv
// Testbench top: stimulus for the gap buffer block and the final verdict.
module gap_buffer_with_markers_unit_tb;
    import gbm_pkg::*;

    localparam int  RANDOM_CMDS = 1220;
    localparam int  FILL_CMDS   = 300;    // one long run of inserts at the end
    localparam longint CYCLE_LIMIT = 64'd40_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // opcode, byte_value, count, position, marker_index, advance
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // status, read_byte, reported_position, text_length, modified
    int          fail_count, pending_count, result_count;
    longint      cycle_count;
    bit          quiet_phase;    // no idling on either side
    int          sink_gap;

    gap_buffer_with_markers_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    gap_buffer_with_markers_unit_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("FAIL gap_buffer_with_markers_unit");
                $finish;
            end
        end
    end

    // Result side: tready drops in random bursts unless in the quiet phase.
    initial
    begin
        m_axis_tready = 1'b0;
        sink_gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_gap > 0)
                sink_gap--;
            else if (!quiet_phase && $urandom_range(0, 9) == 0)
                sink_gap = $urandom_range(1, 7);
            m_axis_tready <= (sink_gap == 0);
        end
    end

    function automatic logic [47:0] pack_cmd(opcode_t op, logic [7:0] bv, logic [12:0] cnt,
                                             logic [12:0] pos, logic [2:0] mi, logic adv);
        return {7'd0, adv, mi, pos, cnt, bv, op};
    endfunction

    // One command transfer; random idle burst before it when allowed.
    task automatic send_cmd(input logic [47:0] d);
        int gap;
        if (!quiet_phase && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Random command, weighted toward edits near the text with full-range noise.
    task automatic send_random(input int text_hint);
        int            sel;
        opcode_t       op;
        logic [12:0]   cnt, pos;
        sel = $urandom_range(0, 99);
        if (sel < 35)      op = OP_INSERT;
        else if (sel < 47) op = OP_DELETE;
        else if (sel < 57) op = OP_GOTO;
        else if (sel < 70) op = OP_READ;
        else if (sel < 80) op = OP_SET_MARK;
        else if (sel < 91) op = OP_READ_MARK;
        else if (sel < 97) op = OP_DETACH;
        else               op = OP_NOP;
        cnt = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, 6));
        pos = ($urandom_range(0, 9) == 0) ? 13'($urandom) : 13'($urandom_range(0, text_hint + 2));
        send_cmd(pack_cmd(op, 8'($urandom), cnt, pos, 3'($urandom), 1'($urandom)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        quiet_phase = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-text corner cases, markers, extremes of every field.
        send_cmd(pack_cmd(OP_READ, 8'h00, 13'd0, 13'd0, 3'd0, 1'b0));      // read on empty
        send_cmd(pack_cmd(OP_READ_MARK, 8'h00, 13'd0, 13'd0, 3'd3, 1'b0)); // detached marker
        send_cmd(pack_cmd(OP_DETACH, 8'h00, 13'd0, 13'd0, 3'd3, 1'b0));    // detach detached
        send_cmd(pack_cmd(OP_DELETE, 8'h00, 13'd0, 13'd0, 3'd0, 1'b0));    // zero count
        send_cmd(pack_cmd(OP_DELETE, 8'h00, 13'd5, 13'd0, 3'd0, 1'b0));    // cursor at end
        send_cmd(pack_cmd(OP_SET_MARK, 8'h00, 13'd0, 13'd0, 3'd0, 1'b1));
        send_cmd(pack_cmd(OP_SET_MARK, 8'h00, 13'd0, 13'd0, 3'd7, 1'b0));
        send_cmd(pack_cmd(OP_INSERT, 8'hFF, 13'd0, 13'd0, 3'd0, 1'b0));
        send_cmd(pack_cmd(OP_INSERT, 8'h00, 13'd0, 13'd0, 3'd0, 1'b0));
        send_cmd(pack_cmd(OP_INSERT, 8'hA5, 13'd0, 13'd0, 3'd0, 1'b0));
        send_cmd(pack_cmd(OP_READ_MARK, 8'h00, 13'd0, 13'd0, 3'd0, 1'b0));
        send_cmd(pack_cmd(OP_READ_MARK, 8'h00, 13'd0, 13'd0, 3'd7, 1'b0));
        send_cmd(pack_cmd(OP_GOTO, 8'h00, 13'd0, 13'h1FFF, 3'd0, 1'b0));   // clipped goto
        send_cmd(pack_cmd(OP_SET_MARK, 8'h00, 13'd0, 13'h1FFF, 3'd5, 1'b1)); // clipped mark
        send_cmd(pack_cmd(OP_GOTO, 8'h00, 13'd0, 13'd1, 3'd0, 1'b0));
        send_cmd(pack_cmd(OP_READ, 8'h00, 13'd0, 13'd2, 3'd0, 1'b0));
        send_cmd(pack_cmd(OP_READ, 8'h00, 13'd0, 13'd3, 3'd0, 1'b0));      // past end
        send_cmd(pack_cmd(OP_DELETE, 8'h00, 13'h1FFF, 13'd0, 3'd0, 1'b0)); // clipped delete
        send_cmd(pack_cmd(OP_READ_MARK, 8'h00, 13'd0, 13'd0, 3'd5, 1'b0));
        send_cmd(pack_cmd(OP_NOP, 8'h00, 13'h1FFF, 13'h1FFF, 3'd7, 1'b1));
        send_cmd(pack_cmd(OP_DETACH, 8'h00, 13'd0, 13'd0, 3'd7, 1'b0));
        wait_drained();   // sender holds off until every result is back

        // Random traffic on short text.
        for (int n = 0; n < RANDOM_CMDS / 2; n++)
            send_random(20);

        // Long insert run at the end, then long gap moves and a long delete.
        send_cmd(pack_cmd(OP_GOTO, 8'h00, 13'd0, 13'h1FFF, 3'd0, 1'b0));
        for (int n = 0; n < FILL_CMDS; n++)
            send_cmd(pack_cmd(OP_INSERT, 8'($urandom), 13'd0, 13'd0, 3'd0, 1'b0));
        send_cmd(pack_cmd(OP_READ, 8'h00, 13'd0, 13'd4095, 3'd0, 1'b0));
        send_cmd(pack_cmd(OP_GOTO, 8'h00, 13'd0, 13'd7, 3'd0, 1'b0));
        send_cmd(pack_cmd(OP_DELETE, 8'h00, 13'h1000, 13'd0, 3'd0, 1'b0));

        // Last part without idling on either side.
        quiet_phase = 1'b1;
        for (int n = 0; n < RANDOM_CMDS / 2; n++)
            send_random(20);
        wait_drained();
        repeat (64) @(negedge clk);

        $display("covered: corner cases, %0d results incl. a long insert run and long deletes",
                 result_count);
        $display("random edits, marker tracking and read-back with stalls on both sides");
        if (fail_count == 0 && pending_count == 0)
            $display("PASS gap_buffer_with_markers_unit");
        else
            $display("FAIL gap_buffer_with_markers_unit");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/gbm_pkg.sv
src/gbm_ctrl.sv
src/gbm_datapath.sv
src/gap_buffer_with_markers_unit.sv
src/gbm_checker.sv
test/gap_buffer_with_markers_unit_checker.sv
test/gap_buffer_with_markers_unit_tb.sv
